@@ hdl/dzoc_pkg.sv @@
`default_nettype none
package dzoc_pkg;

	localparam int ZONE_COUNT  = 3;
	localparam int DEPTH_W     = 16;
	localparam int SUM_W       = 32;
	localparam int CNT_W       = 19;
	localparam int IMG_W       = 11;
	localparam int POS_W       = 13;
	localparam int CFG_ADDR_W  = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int REM_W       = CNT_W + 1;
	localparam int STEP_W      = $clog2(SUM_W);
	localparam int RECIP_W     = 10;
	localparam int RECIP_SHIFT = 11;
	localparam logic [RECIP_W-1:0] RECIP_3 = 10'd683;
	localparam int QUEUE_DEPTH = 2;
	localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
	localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] ZONE_LEFT  = 2'd0;
	localparam logic [1:0] ZONE_FRONT = 2'd1;
	localparam logic [1:0] ZONE_RIGHT = 2'd2;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_IMAGE_WIDTH    = 2'd0,
		REG_MIN_VALID      = 2'd1,
		REG_MAX_VALID      = 2'd2,
		REG_NEAR_THRESHOLD = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		CODE_CLEAR = 2'd0,
		CODE_FRONT = 2'd1,
		CODE_LEFT  = 2'd2,
		CODE_RIGHT = 2'd3
	} zone_code_t;

	typedef logic [SUM_W-1:0] sum_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [DEPTH_W-1:0] depth_t;

	typedef struct packed {
		sum_t [ZONE_COUNT-1:0] sum;
		cnt_t [ZONE_COUNT-1:0] cnt;
	} frame_acc_t;

	typedef struct packed {
		logic [IMG_W-1:0] image_width;
		depth_t           min_valid;
		depth_t           max_valid;
		depth_t           near_threshold;
	} cfg_t;

endpackage
`default_nettype wire

@@ hdl/dzoc_front.sv @@
`default_nettype none
module dzoc_front #(
	parameter int MAX_WIDTH = 1024
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire dzoc_pkg::cfg_t     cfg,
	input  wire logic               take,
	input  wire dzoc_pkg::depth_t   depth_mm,
	input  wire logic               frame_end,
	output logic                    pend,
	output logic                    snap_push,
	output dzoc_pkg::frame_acc_t    snap
);
	import dzoc_pkg::*;

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int PROD_W = POS_W + RECIP_W;

	logic [CW-1:0]     col_q;
	logic [POS_W-1:0]  img_ext, max_ext, w_eff, zw, b2, b3, col_ext, col_inc;
	logic [PROD_W-1:0] prod;
	logic              in_zone, in_window;
	logic [1:0]        zone;

	logic              valid_s1, last_s1, add_s1;
	logic [1:0]        zone_s1;
	depth_t            depth_s1;

	frame_acc_t        acc_q, acc_upd;
	logic [SUM_W:0]    sum_add;

	always_comb begin
		img_ext = POS_W'(cfg.image_width);
		max_ext = POS_W'(MAX_WIDTH);
		w_eff   = (img_ext > max_ext) ? max_ext : img_ext;
		prod    = PROD_W'(w_eff) * PROD_W'(RECIP_3);
		zw      = POS_W'(prod >> RECIP_SHIFT);
		b2      = zw + zw;
		b3      = b2 + zw;
		col_ext = POS_W'(col_q);
		col_inc = col_ext + POS_W'(1);
		in_zone = 1'b1;
		zone    = ZONE_LEFT;
		if (zw == '0) begin
			in_zone = 1'b0;
		end else if (col_ext < zw) begin
			zone = ZONE_LEFT;
		end else if (col_ext < b2) begin
			zone = ZONE_FRONT;
		end else if (col_ext < b3) begin
			zone = ZONE_RIGHT;
		end else begin
			in_zone = 1'b0;
		end
		in_window = (depth_mm > cfg.min_valid) && (depth_mm < cfg.max_valid);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
			if (take) begin
				if (frame_end || (col_inc >= w_eff)) begin
					col_q <= '0;
				end else begin
					col_q <= CW'(col_inc);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			depth_s1 <= depth_mm;
			add_s1   <= in_zone && in_window;
			zone_s1  <= zone;
			last_s1  <= frame_end;
		end
	end

	always_comb begin
		acc_upd = acc_q;
		sum_add = '0;
		for (int z = 0; z < ZONE_COUNT; z++) begin
			if (add_s1 && (zone_s1 == 2'(z))) begin
				sum_add = {1'b0, acc_q.sum[z]} + (SUM_W + 1)'(depth_s1);
				acc_upd.sum[z] = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
				if (acc_q.cnt[z] != '1) begin
					acc_upd.cnt[z] = acc_q.cnt[z] + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (valid_s1) begin
			acc_q <= last_s1 ? '0 : acc_upd;
		end
	end

	assign pend      = valid_s1 && last_s1;
	assign snap_push = valid_s1 && last_s1;
	assign snap      = acc_upd;

endmodule
`default_nettype wire

@@ hdl/dzoc_queue.sv @@
`default_nettype none
module dzoc_queue (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          wr,
	input  wire dzoc_pkg::frame_acc_t          din,
	input  wire logic                          rd,
	output dzoc_pkg::frame_acc_t               head,
	output logic                               nonempty,
	output logic [dzoc_pkg::Q_CNT_W-1:0]       count
);
	import dzoc_pkg::*;

	frame_acc_t         mem_q [QUEUE_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head     = mem_q[rd_ptr_q];
	assign nonempty = (count_q != '0);
	assign count    = count_q;

endmodule
`default_nettype wire

@@ hdl/dzoc_back.sv @@
`default_nettype none
module dzoc_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire dzoc_pkg::depth_t    near_threshold,
	input  wire logic                q_valid,
	input  wire dzoc_pkg::frame_acc_t q_head,
	output logic                     q_pop,
	input  wire logic                pop,
	output logic                     empty,
	output logic [1:0]               zone_code,
	output dzoc_pkg::depth_t         left_mean,
	output dzoc_pkg::depth_t         front_mean,
	output dzoc_pkg::depth_t         right_mean,
	output logic                     left_seen,
	output logic                     front_seen,
	output logic                     right_seen
);
	import dzoc_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t                      state_q;
	logic                        out_valid_q;
	logic [1:0]                  zone_q, zone_nx;
	logic [STEP_W-1:0]           step_q;
	sum_t                        dvd_q, dvd_nx;
	logic [REM_W-1:0]            rem_q, trial, rem_nx;
	cnt_t                        divisor_q;
	logic [REM_W:0]              diff;
	logic                        qbit;
	depth_t                      clamp;
	depth_t [ZONE_COUNT-1:0]     mean_q, mean_show;
	logic [ZONE_COUNT-1:0]       seen;
	zone_code_t                  code;
	logic                        out_free, out_take;

	always_comb begin
		trial   = {rem_q[REM_W-2:0], dvd_q[SUM_W-1]};
		diff    = {1'b0, trial} - (REM_W + 1)'(divisor_q);
		qbit    = !diff[REM_W];
		rem_nx  = qbit ? diff[REM_W-1:0] : trial;
		dvd_nx  = {dvd_q[SUM_W-2:0], qbit};
		clamp   = (|dvd_nx[SUM_W-1:DEPTH_W]) ? '1 : dvd_nx[DEPTH_W-1:0];
		zone_nx = zone_q + 2'd1;
		for (int z = 0; z < ZONE_COUNT; z++) begin
			seen[z]      = (q_head.cnt[z] != '0);
			mean_show[z] = seen[z] ? mean_q[z] : '0;
		end
		if (seen[ZONE_FRONT] && (mean_show[ZONE_FRONT] < near_threshold)) begin
			code = CODE_FRONT;
		end else if (seen[ZONE_LEFT] && (mean_show[ZONE_LEFT] < near_threshold)) begin
			code = CODE_LEFT;
		end else if (seen[ZONE_RIGHT] && (mean_show[ZONE_RIGHT] < near_threshold)) begin
			code = CODE_RIGHT;
		end else begin
			code = CODE_CLEAR;
		end
	end

	assign out_take = pop && out_valid_q;
	assign out_free = !out_valid_q || pop;
	assign q_pop    = (state_q == ST_FIN) && out_free;
	assign empty    = !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			zone_q      <= ZONE_LEFT;
			step_q      <= '0;
			dvd_q       <= '0;
			rem_q       <= '0;
			divisor_q   <= '0;
			mean_q      <= '0;
			zone_code   <= CODE_CLEAR;
			left_mean   <= '0;
			front_mean  <= '0;
			right_mean  <= '0;
			left_seen   <= 1'b0;
			front_seen  <= 1'b0;
			right_seen  <= 1'b0;
		end else begin
			if (out_take && !q_pop) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						zone_q    <= ZONE_LEFT;
						dvd_q     <= q_head.sum[ZONE_LEFT];
						divisor_q <= q_head.cnt[ZONE_LEFT];
						rem_q     <= '0;
						step_q    <= STEP_W'(SUM_W - 1);
						state_q   <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (step_q != '0) begin
						dvd_q  <= dvd_nx;
						rem_q  <= rem_nx;
						step_q <= step_q - 1'b1;
					end else begin
						mean_q[zone_q] <= clamp;
						if (zone_q == ZONE_RIGHT) begin
							state_q <= ST_FIN;
						end else begin
							zone_q    <= zone_nx;
							dvd_q     <= q_head.sum[zone_nx];
							divisor_q <= q_head.cnt[zone_nx];
							rem_q     <= '0;
							step_q    <= STEP_W'(SUM_W - 1);
						end
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						zone_code   <= code;
						left_mean   <= mean_show[ZONE_LEFT];
						front_mean  <= mean_show[ZONE_FRONT];
						right_mean  <= mean_show[ZONE_RIGHT];
						left_seen   <= seen[ZONE_LEFT];
						front_seen  <= seen[ZONE_FRONT];
						right_seen  <= seen[ZONE_RIGHT];
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

@@ hdl/depth_zone_obstacle_classifier_unit.sv @@
// Pixels: one word accepted per cycle while full is low; full rises while the two-entry frame
// queue, counting a frame end still in the accumulate stage, has no free entry.
// Frame result: the frame-end word passes the accumulate stage and the frame queue; the back end
// then loads each zone in turn into the shared 1-bit-per-cycle divider for the three zone means and
// registers the outputs, taking no new frame until the output register is free for this one.
// Reset (arst_n low, asynchronous): registers to 640/50/10000/800, counters, sums and queue clear.
`default_nettype none
module depth_zone_obstacle_classifier_unit #(
	parameter int MAX_WIDTH = 1024
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [dzoc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  wire logic [dzoc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  wire logic                              push,
	output logic                                   full,
	input  wire logic [15:0]                       depth_mm,
	input  wire logic                              frame_end,
	output logic                                   empty,
	input  wire logic                              pop,
	output logic [1:0]                             zone_code,
	output logic [15:0]                            left_mean,
	output logic [15:0]                            front_mean,
	output logic [15:0]                            right_mean,
	output logic                                   left_seen,
	output logic                                   front_seen,
	output logic                                   right_seen
);
	import dzoc_pkg::*;

	cfg_t               cfg_q;
	logic               take, pend, snap_push, q_valid, q_pop;
	frame_acc_t         snap, q_head;
	logic [Q_CNT_W-1:0] q_count;
	logic [Q_CNT_W:0]   q_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width    <= IMG_W'(640);
			cfg_q.min_valid      <= DEPTH_W'(50);
			cfg_q.max_valid      <= DEPTH_W'(10000);
			cfg_q.near_threshold <= DEPTH_W'(800);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_addr))
				REG_IMAGE_WIDTH:    cfg_q.image_width    <= cfg_wdata[IMG_W-1:0];
				REG_MIN_VALID:      cfg_q.min_valid      <= cfg_wdata;
				REG_MAX_VALID:      cfg_q.max_valid      <= cfg_wdata;
				REG_NEAR_THRESHOLD: cfg_q.near_threshold <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign q_load = (Q_CNT_W + 1)'(q_count) + (Q_CNT_W + 1)'(pend);
	assign full   = (q_load >= (Q_CNT_W + 1)'(QUEUE_DEPTH));
	assign take   = push && !full;

	dzoc_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.take      (take),
		.depth_mm  (depth_mm),
		.frame_end (frame_end),
		.pend      (pend),
		.snap_push (snap_push),
		.snap      (snap)
	);

	dzoc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (snap_push),
		.din      (snap),
		.rd       (q_pop),
		.head     (q_head),
		.nonempty (q_valid),
		.count    (q_count)
	);

	dzoc_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.near_threshold (cfg_q.near_threshold),
		.q_valid        (q_valid),
		.q_head         (q_head),
		.q_pop          (q_pop),
		.pop            (pop),
		.empty          (empty),
		.zone_code      (zone_code),
		.left_mean      (left_mean),
		.front_mean     (front_mean),
		.right_mean     (right_mean),
		.left_seen      (left_seen),
		.front_seen     (front_seen),
		.right_seen     (right_seen)
	);

endmodule
`default_nettype wire
